/* rtl/smpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int CAPACITY_DEF   = 30;
    localparam int KEY_BITS_DEF   = 10;
    localparam int OWNER_BITS_DEF = 22;

    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PUT,
        S_POP,
        S_FIN
    } t_state;

endpackage

/* rtl/sorted_min_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded job queue held in ascending size order in a circular store.
//
// Input channel (i_in_valid / o_in_stall) carries one transaction per job
// request: i_kind selects insert or remove of the smallest job. Each request
// gives exactly one result transaction on the output channel (o_out_valid /
// i_out_stall) with status, the removed job and the occupancy afterwards.
// Equal sizes: the newest job is served first.
// A remove reads the head job, takes it out in S_POP and passes its result
// through S_FIN to the output register. A refused request goes straight to
// S_FIN. An insert walks back from the tail through the single memory read
// port, one stored job per cycle, moving every job whose size is not smaller,
// then writes the new job into the hole in S_PUT.
// The block accepts one request at a time; o_in_stall is high while a
// request is in progress. A finished result waits in the output register
// while i_out_stall is high and the next request may already be taken in;
// its result then waits until the output register is free.
// Reset empties the queue at once; the store content is not cleared.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue #(
    parameter int CAPACITY   = smpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = smpq_pkg::KEY_BITS_DEF,
    parameter int OWNER_BITS = smpq_pkg::OWNER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [KEY_BITS-1:0]           i_job_size,
    input  logic [OWNER_BITS-1:0]         i_job_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [smpq_pkg::STATUS_W-1:0] o_status,
    output logic [KEY_BITS-1:0]           o_out_size,
    output logic [OWNER_BITS-1:0]         o_out_id,
    output logic [smpq_pkg::OCC_W-1:0]    o_occupancy
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENT_W   = KEY_BITS + OWNER_BITS;
    localparam int EXT_W   = (CNT_W > smpq_pkg::OCC_W) ? CNT_W : smpq_pkg::OCC_W;

    function automatic logic [IDX_W-1:0] f_inc(input logic [IDX_W-1:0] p);
        f_inc = (p == IDX_W'(CAPACITY - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] f_dec(input logic [IDX_W-1:0] p);
        f_dec = (p == '0) ? IDX_W'(CAPACITY - 1) : p - IDX_W'(1);
    endfunction

    smpq_pkg::t_state r_state, n_state;

    logic [ENT_W-1:0] r_mem [CAPACITY];
    logic [ENT_W-1:0] r_rd_data;

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [IDX_W-1:0] r_hole, n_hole;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_walk, n_walk;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [OWNER_BITS-1:0] r_owner, n_owner;
    logic                  r_kind, n_kind;

    logic [smpq_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [KEY_BITS-1:0]           r_res_size, n_res_size;
    logic [OWNER_BITS-1:0]         r_res_id, n_res_id;

    logic                          r_out_valid, n_out_valid;
    logic [smpq_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [KEY_BITS-1:0]           r_out_size, n_out_size;
    logic [OWNER_BITS-1:0]         r_out_id, n_out_id;
    logic [smpq_pkg::OCC_W-1:0]    r_out_occ, n_out_occ;

    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    logic [ENT_W-1:0] w_wr_data;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;

    logic                w_accept;
    logic                w_out_free;
    logic                w_ge;
    logic [EXT_W-1:0]    w_cnt_ext;
    logic [KEY_BITS-1:0] w_rd_key;

    assign w_accept   = i_in_valid && (r_state == smpq_pkg::S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_rd_key   = r_rd_data[ENT_W-1:OWNER_BITS];
    assign w_ge       = (w_rd_key >= r_key);
    assign w_cnt_ext  = EXT_W'(r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            smpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == smpq_pkg::KIND_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_state = smpq_pkg::S_FIN;
                        end else if (r_count == '0) begin
                            n_state = smpq_pkg::S_PUT;
                        end else begin
                            n_state = smpq_pkg::S_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_state = smpq_pkg::S_FIN;
                        end else begin
                            n_state = smpq_pkg::S_POP;
                        end
                    end
                end
            end
            smpq_pkg::S_CMP: begin
                if (!w_ge || r_walk == CNT_W'(1)) begin
                    n_state = smpq_pkg::S_PUT;
                end
            end
            smpq_pkg::S_PUT: n_state = smpq_pkg::S_FIN;
            smpq_pkg::S_POP: n_state = smpq_pkg::S_FIN;
            smpq_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = smpq_pkg::S_IDLE;
                end
            end
            default: n_state = smpq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_hole       = r_hole;
        n_count      = r_count;
        n_walk       = r_walk;
        n_key        = r_key;
        n_owner      = r_owner;
        n_kind       = r_kind;
        n_res_status = r_res_status;
        n_res_size   = r_res_size;
        n_res_id     = r_res_id;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_size   = r_out_size;
        n_out_id     = r_out_id;
        n_out_occ    = r_out_occ;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_hole;
        w_wr_data    = {r_key, r_owner};
        w_rd_en      = 1'b0;
        w_rd_addr    = r_head;
        case (r_state)
            smpq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_key        = i_job_size;
                    n_owner      = i_job_id;
                    n_kind       = i_kind;
                    n_res_size   = '0;
                    n_res_id     = '0;
                    n_res_status = smpq_pkg::ST_DONE;
                    n_hole       = r_tail;
                    n_walk       = r_count;
                    if (i_kind == smpq_pkg::KIND_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_res_status = smpq_pkg::ST_FULL;
                        end else begin
                            w_rd_en   = (r_count != '0);
                            w_rd_addr = f_dec(r_tail);
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = smpq_pkg::ST_EMPTY;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = r_head;
                        end
                    end
                end
            end
            smpq_pkg::S_CMP: begin
                if (w_ge) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_hole;
                    w_wr_data = r_rd_data;
                    n_hole    = f_dec(r_hole);
                    n_walk    = r_walk - CNT_W'(1);
                    w_rd_en   = (r_walk != CNT_W'(1));
                    w_rd_addr = f_dec(f_dec(r_hole));
                end
            end
            smpq_pkg::S_PUT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_hole;
                w_wr_data = {r_key, r_owner};
                n_tail    = f_inc(r_tail);
                n_count   = r_count + CNT_W'(1);
            end
            smpq_pkg::S_POP: begin
                n_res_size = w_rd_key;
                n_res_id   = r_rd_data[OWNER_BITS-1:0];
                n_head     = f_inc(r_head);
                n_count    = r_count - CNT_W'(1);
            end
            smpq_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_size   = r_res_size;
                    n_out_id     = r_res_id;
                    n_out_occ    = w_cnt_ext[smpq_pkg::OCC_W-1:0];
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smpq_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hole       <= n_hole;
        r_walk       <= n_walk;
        r_key        <= n_key;
        r_owner      <= n_owner;
        r_kind       <= n_kind;
        r_res_status <= n_res_status;
        r_res_size   <= n_res_size;
        r_res_id     <= n_res_id;
        r_out_status <= n_out_status;
        r_out_size   <= n_out_size;
        r_out_id     <= n_out_id;
        r_out_occ    <= n_out_occ;
    end

    assign o_in_stall  = (r_state != smpq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_size  = r_out_size;
    assign o_out_id    = r_out_id;
    assign o_occupancy = r_out_occ;

    // head, tail and count stay consistent
    logic [CNT_W:0] w_chk_sum;
    logic [CNT_W:0] w_chk_tail;
    assign w_chk_sum  = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
    assign w_chk_tail = (w_chk_sum >= (CNT_W+1)'(CAPACITY)) ?
                        w_chk_sum - (CNT_W+1)'(CAPACITY) : w_chk_sum;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_ring_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smpq_pkg::S_IDLE) |-> (w_chk_tail == (CNT_W+1)'(r_tail)))
        else $error("tail does not match head plus count");

    a_walk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smpq_pkg::S_CMP) |->
        (r_walk != '0 && r_kind == smpq_pkg::KIND_INSERT))
        else $error("compare step with nothing left to walk");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smpq_pkg::S_POP) |-> (r_count != '0 && r_kind == smpq_pkg::KIND_REMOVE))
        else $error("remove from empty queue");

    a_fin_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smpq_pkg::S_FIN && r_out_valid && i_out_stall) |=>
        (r_state == smpq_pkg::S_FIN))
        else $error("result dropped while output stalled");

endmodule
